// ===== rtl/barometric_sensor_compensation_macros.svh =====
// Assertion macros shared by the compensation block.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compensation assertion failed");

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compensation assertion failed");

`endif

// ===== rtl/bsc_pkg.sv =====
// Shared types and constants of the barometric compensation pipeline.
package bsc_pkg;

    typedef logic [63:0] word64_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CAL_T  = 2'd0;
    localparam logic [1:0] REG_CAL_P1 = 2'd1;
    localparam logic [1:0] REG_CAL_P2 = 2'd2;
    localparam logic [1:0] REG_CAL_P9 = 2'd3;

    // Divider width and total pipeline depth
    localparam int DIV_BITS   = 64;
    localparam int PIPE_DEPTH = 87;

    // Per-request side information that travels with the pipeline
    typedef struct packed {
        logic        valid;
        logic [19:0] adc_p;
        logic [31:0] fine;
        logic [31:0] tc;
        logic        invalid;
    } side_t;

endpackage

// ===== rtl/bsc_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
module bsc_mul64
    import bsc_pkg::*;
(
    input  logic    clk,
    input  word64_t a,
    input  word64_t b,
    output word64_t p
);

    logic [63:0] ll_reg, ll_next;
    logic [31:0] lh_reg, lh_next;
    logic [31:0] hl_reg, hl_next;
    word64_t     p_reg, p_next;

    // Form the three partial products that reach the low word
    always_comb
    begin
        ll_next = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        lh_next = a[31:0] * b[63:32];
        hl_next = a[63:32] * b[31:0];
        p_next  = ll_reg + {lh_reg + hl_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        ll_reg <= ll_next;
        lh_reg <= lh_next;
        hl_reg <= hl_next;
        p_reg  <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/bsc_div64.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
module bsc_div64
    import bsc_pkg::*;
(
    input  logic    clk,
    input  word64_t dividend,
    input  word64_t divisor,
    output word64_t quotient
);

    word64_t rem_reg [0:DIV_BITS];
    word64_t dq_reg  [0:DIV_BITS];
    word64_t ub_reg  [0:DIV_BITS];
    logic    neg_reg [0:DIV_BITS];
    word64_t rem_next[0:DIV_BITS];
    word64_t dq_next [0:DIV_BITS];
    logic [64:0] trial_w[1:DIV_BITS];
    logic    qbit_w  [1:DIV_BITS];
    word64_t quo_reg, quo_next;

    always_comb
    begin
        // Take magnitudes and note the result sign
        rem_next[0] = '0;
        dq_next[0]  = dividend[63] ? (64'd0 - dividend) : dividend;
        // Restoring step per stage: shift in one dividend bit, subtract if it fits
        for (int i = 1; i <= DIV_BITS; i++)
        begin
            trial_w[i]  = {rem_reg[i-1], dq_reg[i-1][63]};
            qbit_w[i]   = trial_w[i] >= {1'b0, ub_reg[i-1]};
            rem_next[i] = qbit_w[i] ? 64'(trial_w[i] - {1'b0, ub_reg[i-1]})
                                    : trial_w[i][63:0];
            dq_next[i]  = {dq_reg[i-1][62:0], qbit_w[i]};
        end
        // Apply the sign
        quo_next = neg_reg[DIV_BITS] ? (64'd0 - dq_reg[DIV_BITS]) : dq_reg[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        dq_reg[0]  <= dq_next[0];
        ub_reg[0]  <= divisor[63] ? (64'd0 - divisor) : divisor;
        neg_reg[0] <= dividend[63] ^ divisor[63];
        for (int i = 1; i <= DIV_BITS; i++)
        begin
            rem_reg[i] <= rem_next[i];
            dq_reg[i]  <= dq_next[i];
            ub_reg[i]  <= ub_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
        end
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Top level of the barometric compensation pipeline with its register port.
//
// Each request carries a raw temperature and a raw pressure reading and is
// taken on any cycle: busy is always low, so one request per clock is
// sustained. The result appears at the end of the pipeline, for one cycle,
// with done high; the receiver cannot stall it. The latency is set by the
// 64-stage pressure divider plus five 64-bit multiplies, each cut into two
// stages of 32-bit partial products, and the temperature stages ahead of them.
// Calibration registers sit on the APB port at byte addresses 0, 8, 16, 24
// and may be written only while no request is in flight.
`include "barometric_sensor_compensation_macros.svh"

module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               done,
    output logic signed [31:0] temperature_centi,
    output logic signed [31:0] fine_temperature,
    output logic [31:0]        pressure_pa,
    output logic               pressure_invalid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    // Calibration registers
    logic [47:0] cal_t_reg;
    logic [63:0] cal_p1_reg;
    logic [63:0] cal_p2_reg;
    logic [15:0] cal_p9_reg;
    logic        wr_w;

    // Coefficients
    logic [15:0] t1_w;
    logic [31:0] t2_w, t3_w;
    word64_t     p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

    // Pipeline registers
    side_t       side_reg [0:PIPE_DEPTH-1];
    side_t       side_next[0:PIPE_DEPTH-1];
    logic [31:0] x_reg, x_next, d_reg, d_next;
    logic [31:0] aprod_reg, aprod_next, dd_reg, dd_next;
    logic [31:0] a_reg, a_next, b1prod_reg, b1prod_next;
    logic [31:0] fine_next, tc_next;
    word64_t     v1_reg, v1_next;
    word64_t     vv_w, vp5_w, vp2_w, vvp6_w, vvp3_w, v1c_w;
    word64_t     vp5_d1_reg, vp5_d2_reg, vp2_d1_reg, vp2_d2_reg;
    word64_t     v2_reg, v2_next, x47_reg, x47_next;
    word64_t     num_reg, num_next, num_d1_reg, num_d2_reg;
    word64_t     v1d_reg, v1d_next;
    word64_t     quo_w;
    word64_t     q_reg, q_next, p0_reg;
    word64_t     qq_w, p8p_w, v1e_w;
    word64_t     p1d_reg, p2d_reg, p3d_reg, p4d_reg;
    word64_t     p8p_d1_reg, p8p_d2_reg;
    word64_t     s_reg, s_next, t_reg, t_next;
    word64_t     bias_w, pres_w;
    logic [31:0] pa_reg, pa_next;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_w   = psel && penable && pwrite;

    // Write calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_t_reg  <= '0;
            cal_p1_reg <= '0;
            cal_p2_reg <= '0;
            cal_p9_reg <= '0;
        end
        else if (wr_w)
        begin
            unique case (paddr[4:3])
                REG_CAL_T:  cal_t_reg  <= pwdata[47:0];
                REG_CAL_P1: cal_p1_reg <= pwdata;
                REG_CAL_P2: cal_p2_reg <= pwdata;
                REG_CAL_P9: cal_p9_reg <= pwdata[15:0];
            endcase
        end
    end

    // Read back calibration registers
    always_comb
    begin
        unique case (paddr[4:3])
            REG_CAL_T:  prdata = {16'b0, cal_t_reg};
            REG_CAL_P1: prdata = cal_p1_reg;
            REG_CAL_P2: prdata = cal_p2_reg;
            REG_CAL_P9: prdata = {48'b0, cal_p9_reg};
        endcase
    end

    // Unpack coefficients
    assign t1_w = cal_t_reg[15:0];
    assign t2_w = {{16{cal_t_reg[31]}}, cal_t_reg[31:16]};
    assign t3_w = {{16{cal_t_reg[47]}}, cal_t_reg[47:32]};
    assign p1_w = {48'b0, cal_p1_reg[15:0]};
    assign p2_w = {{48{cal_p1_reg[31]}}, cal_p1_reg[31:16]};
    assign p3_w = {{48{cal_p1_reg[47]}}, cal_p1_reg[47:32]};
    assign p4_w = {{48{cal_p1_reg[63]}}, cal_p1_reg[63:48]};
    assign p5_w = {{48{cal_p2_reg[15]}}, cal_p2_reg[15:0]};
    assign p6_w = {{48{cal_p2_reg[31]}}, cal_p2_reg[31:16]};
    assign p7_w = {{48{cal_p2_reg[47]}}, cal_p2_reg[47:32]};
    assign p8_w = {{48{cal_p2_reg[63]}}, cal_p2_reg[63:48]};
    assign p9_w = {{48{cal_p9_reg[15]}}, cal_p9_reg};

    // Temperature stages and scalar pressure stages
    always_comb
    begin
        x_next      = {15'b0, raw_temperature[19:3]} - {15'b0, t1_w, 1'b0};
        d_next      = {16'b0, raw_temperature[19:4]} - {16'b0, t1_w};
        aprod_next  = x_reg * t2_w;
        dd_next     = d_reg * d_reg;
        a_next      = $unsigned($signed(aprod_reg) >>> 11);
        b1prod_next = $unsigned($signed(dd_reg) >>> 12) * t3_w;
        fine_next   = a_reg + $unsigned($signed(b1prod_reg) >>> 14);
        tc_next     = $unsigned($signed(side_reg[3].fine * 32'd5 + 32'd128) >>> 8);
        v1_next     = {{32{side_reg[3].fine[31]}}, side_reg[3].fine} - 64'd128000;
        v2_next     = vvp6_w + (vp5_d2_reg << 17) + (p4_w << 35);
        x47_next    = 64'h0000_8000_0000_0000
                    + ($unsigned($signed(vvp3_w) >>> 8) + (vp2_d2_reg << 12));
        num_next    = (((64'd1048576 - {44'b0, side_reg[9].adc_p}) << 31) - v2_reg)
                    * 64'd3125;
        v1d_next    = $unsigned($signed(v1c_w) >>> 33);
        q_next      = $unsigned($signed(quo_w) >>> 13);
        s_next      = p4d_reg + $unsigned($signed(v1e_w) >>> 25)
                    + $unsigned($signed(p8p_d2_reg) >>> 19);
        t_next      = $unsigned($signed(s_reg) >>> 8) + (p7_w << 4);
        // Divide by 256 truncating toward zero
        bias_w      = t_reg + (t_reg[63] ? 64'd255 : 64'd0);
        pres_w      = $unsigned($signed(bias_w) >>> 8);
        pa_next     = side_reg[85].invalid ? 32'd0 : pres_w[31:0];
    end

    // Advance side information and drop in fields as they are computed
    always_comb
    begin
        side_next[0].valid   = start && !busy;
        side_next[0].adc_p   = raw_pressure;
        side_next[0].fine    = '0;
        side_next[0].tc      = '0;
        side_next[0].invalid = 1'b0;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[3].fine     = fine_next;
        side_next[4].tc       = tc_next;
        side_next[12].invalid = v1d_next == 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        d_reg      <= d_next;
        aprod_reg  <= aprod_next;
        dd_reg     <= dd_next;
        a_reg      <= a_next;
        b1prod_reg <= b1prod_next;
        v1_reg     <= v1_next;
        vp5_d1_reg <= vp5_w;
        vp5_d2_reg <= vp5_d1_reg;
        vp2_d1_reg <= vp2_w;
        vp2_d2_reg <= vp2_d1_reg;
        v2_reg     <= v2_next;
        x47_reg    <= x47_next;
        num_reg    <= num_next;
        num_d1_reg <= num_reg;
        num_d2_reg <= num_d1_reg;
        v1d_reg    <= v1d_next;
        q_reg      <= q_next;
        p0_reg     <= quo_w;
        p1d_reg    <= p0_reg;
        p2d_reg    <= p1d_reg;
        p3d_reg    <= p2d_reg;
        p4d_reg    <= p3d_reg;
        p8p_d1_reg <= p8p_w;
        p8p_d2_reg <= p8p_d1_reg;
        s_reg      <= s_next;
        t_reg      <= t_next;
        pa_reg     <= pa_next;
    end

    // Multipliers and divider
    bsc_mul64 u_mul_vv   (.clk(clk), .a(v1_reg),  .b(v1_reg), .p(vv_w));
    bsc_mul64 u_mul_vp5  (.clk(clk), .a(v1_reg),  .b(p5_w),   .p(vp5_w));
    bsc_mul64 u_mul_vp2  (.clk(clk), .a(v1_reg),  .b(p2_w),   .p(vp2_w));
    bsc_mul64 u_mul_vvp6 (.clk(clk), .a(vv_w),    .b(p6_w),   .p(vvp6_w));
    bsc_mul64 u_mul_vvp3 (.clk(clk), .a(vv_w),    .b(p3_w),   .p(vvp3_w));
    bsc_mul64 u_mul_p1   (.clk(clk), .a(x47_reg), .b(p1_w),   .p(v1c_w));
    bsc_mul64 u_mul_qq   (.clk(clk), .a(q_reg),   .b(q_reg),  .p(qq_w));
    bsc_mul64 u_mul_p8   (.clk(clk), .a(p0_reg),  .b(p8_w),   .p(p8p_w));
    bsc_mul64 u_mul_p9   (.clk(clk), .a(qq_w),    .b(p9_w),   .p(v1e_w));

    bsc_div64 u_div
    (
        .clk      (clk),
        .dividend (num_d2_reg),
        .divisor  (v1d_reg),
        .quotient (quo_w)
    );

    // Drive results
    assign done              = side_reg[PIPE_DEPTH-1].valid;
    assign temperature_centi = $signed(side_reg[PIPE_DEPTH-1].tc);
    assign fine_temperature  = $signed(side_reg[PIPE_DEPTH-1].fine);
    assign pressure_invalid  = side_reg[PIPE_DEPTH-1].invalid;
    assign pressure_pa       = pa_reg;

    // Checks
    `BSC_ASSERT_SAME(a_invalid_zero, done && pressure_invalid, pressure_pa == 32'd0)
    `BSC_ASSERT_NEXT(a_request_enters, start && !busy, side_reg[0].valid)
    `BSC_ASSERT_SAME(a_latency, done, $past(start, PIPE_DEPTH))

endmodule
